// ----- sv/crtpp_pkg.sv -----
// Shared types, register indexes and arithmetic helpers for the CRT pixel post filter.
package crtpp_pkg;

	typedef struct packed {
		logic [7:0] factor;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic bleed;
		logic blur;
		logic vignette;
	} cfg_t;

	// one accepted pixel as handed from the front to the back
	typedef struct packed {
		pixel_t     pixel;
		logic [2:0] fill;
		logic       row_end;
		logic       frame_end;
		logic       emits;
		logic [2:0] first_k;
	} cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_last;
		logic       frame_last;
	} result_t;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BLEED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLUR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIGNETTE = 2'd2;

	// window slots: current pixel sits in slot 4, centre of a mid-row output in slot 2
	localparam logic [2:0] FILL_MAX = 3'd4;
	localparam logic [2:0] K_MID    = 3'd2;
	localparam logic [2:0] K_LAST   = 3'd4;

	// (3*c + n) >> 2
	function automatic logic [7:0] bleed_ch(input logic [7:0] c, input logic [7:0] n);
		logic [9:0] s;
		s = {2'b00, c} + {1'b0, c, 1'b0} + {2'b00, n};
		return s[9:2];
	endfunction

	function automatic pixel_t bleed_px(input pixel_t c, input pixel_t l, input pixel_t r);
		pixel_t p;
		p       = c;
		p.red   = bleed_ch(c.red, l.red);
		p.blue  = bleed_ch(c.blue, r.blue);
		return p;
	endfunction

	// c + (l + r) / 6, saturated; x/6 == (x*171)>>10 for x <= 510
	function automatic logic [7:0] blur_ch(input logic [7:0] c, input logic [7:0] l,
			input logic [7:0] r);
		logic [8:0]  s;
		logic [17:0] q;
		logic [8:0]  v;
		s = {1'b0, l} + {1'b0, r};
		q = {9'd0, s} * 18'd171;
		v = {1'b0, c} + {1'b0, q[17:10]};
		return v[8] ? 8'hFF : v[7:0];
	endfunction

	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] f);
		logic [15:0] p;
		p = {8'd0, c} * {8'd0, f};
		return p[15:8];
	endfunction

endpackage

// ----- sv/crtpp_fifo.sv -----
// Small register-based queue used between front and back and on the result side.
module crtpp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

// ----- sv/crtpp_front.sv -----
// Front end: row position tracking and classification of each accepted pixel.
module crtpp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  crtpp_pkg::pixel_t   pixel,
	input  logic                row_end,
	input  logic                frame_end,
	output crtpp_pkg::cmd_t     cmd
);

	import crtpp_pkg::*;

	logic [2:0] fill_q;
	logic       rend;

	assign rend = row_end || frame_end;

	always_comb begin
		cmd.pixel     = pixel;
		cmd.fill      = fill_q;
		cmd.row_end   = rend;
		cmd.frame_end = frame_end;
		cmd.emits     = rend || (fill_q >= K_MID);
		cmd.first_k   = (rend && (fill_q < K_MID)) ? (K_LAST - fill_q) : K_MID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (rend) begin
				fill_q <= '0;
			end else if (fill_q != FILL_MAX) begin
				fill_q <= fill_q + 3'd1;
			end
		end
	end

endmodule

// ----- sv/crtpp_back.sv -----
// Back end: pixel window, output sequencer and bleed / blur / vignette pipeline.
module crtpp_back #(
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  crtpp_pkg::cfg_t                   cfg,
	input  crtpp_pkg::cmd_t                   cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
	output logic                              res_push,
	output crtpp_pkg::result_t                res
);

	import crtpp_pkg::*;

	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		pixel_t centre;
		pixel_t left;
		pixel_t right;
		logic   blur_on;
		logic   row_last;
		logic   frame_last;
	} stage1_t;

	typedef struct packed {
		pixel_t pixel;
		logic   row_last;
		logic   frame_last;
	} stage2_t;

	pixel_t     win_q [4];
	logic       busy_q;
	logic [2:0] k_q;

	pixel_t     loc [5];
	pixel_t     bl  [5];
	logic [4:0] edge_v;
	logic [2:0] k;
	logic [CW:0] used;
	logic       credit_ok;
	logic       issue;
	logic       done;

	logic    s1_valid_q;
	stage1_t st_s1;
	logic    s2_valid_q;
	stage2_t st_s2;
	stage1_t st_next;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			loc[i] = win_q[i];
		end
		loc[4] = cmd.pixel;
	end

	assign k = busy_q ? k_q : cmd.first_k;

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			edge_v[j] = (3'(j) == (K_LAST - cmd.fill)) || (cmd.row_end && (j == 4));
		end
		bl[0] = loc[0];
		bl[4] = loc[4];
		for (int j = 1; j < 4; j++) begin
			bl[j] = (cfg.bleed && !edge_v[j]) ? bleed_px(loc[j], loc[j-1], loc[j+1]) : loc[j];
		end
	end

	always_comb begin
		st_next.centre     = bl[k];
		st_next.left       = bl[k - 3'd1];
		st_next.right      = (k == K_LAST) ? bl[4] : bl[k + 3'd1];
		st_next.blur_on    = cfg.blur && !edge_v[k] && (k != K_LAST);
		st_next.row_last   = cmd.row_end && (k == K_LAST);
		st_next.frame_last = cmd.frame_end && (k == K_LAST);
	end

	assign used      = {1'b0, out_count} + (CW+1)'(s1_valid_q) + (CW+1)'(s2_valid_q);
	assign credit_ok = used < (CW+1)'(OUT_DEPTH);
	assign issue     = cmd_valid && cmd.emits && credit_ok;
	assign done      = cmd_valid && (!cmd.emits ||
		(credit_ok && (!cmd.row_end || (k == K_LAST))));
	assign cmd_pop   = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			k_q        <= K_MID;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				busy_q <= 1'b1;
				k_q    <= k + 3'd1;
			end
			s1_valid_q <= issue;
			s2_valid_q <= s1_valid_q;
		end
	end

	// entries outside the current row are never used, so no clear on row end
	always_ff @(posedge clk) begin
		if (done) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[3] <= cmd.pixel;
		end
		st_s1 <= st_next;
		st_s2.pixel.factor <= st_s1.centre.factor;
		if (st_s1.blur_on) begin
			st_s2.pixel.red   <= blur_ch(st_s1.centre.red, st_s1.left.red, st_s1.right.red);
			st_s2.pixel.green <= blur_ch(st_s1.centre.green, st_s1.left.green,
				st_s1.right.green);
			st_s2.pixel.blue  <= blur_ch(st_s1.centre.blue, st_s1.left.blue,
				st_s1.right.blue);
		end else begin
			st_s2.pixel.red   <= st_s1.centre.red;
			st_s2.pixel.green <= st_s1.centre.green;
			st_s2.pixel.blue  <= st_s1.centre.blue;
		end
		st_s2.row_last   <= st_s1.row_last;
		st_s2.frame_last <= st_s1.frame_last;
	end

	always_comb begin
		res_push = s2_valid_q;
		if (cfg.vignette) begin
			res.red   = scale_ch(st_s2.pixel.red, st_s2.pixel.factor);
			res.green = scale_ch(st_s2.pixel.green, st_s2.pixel.factor);
			res.blue  = scale_ch(st_s2.pixel.blue, st_s2.pixel.factor);
		end else begin
			res.red   = st_s2.pixel.red;
			res.green = st_s2.pixel.green;
			res.blue  = st_s2.pixel.blue;
		end
		res.row_last   = st_s2.row_last;
		res.frame_last = st_s2.frame_last;
	end

	a_credit : assert property (@(posedge clk) disable iff (!arst_n)
		used <= (CW+1)'(OUT_DEPTH))
		else $error("results in flight exceed result queue space");

	a_busy_head : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cmd_valid && cmd.row_end)
		else $error("row flush in progress without its command");

endmodule

// ----- sv/crt_pixel_postprocess.sv -----
// Top level of the CRT pixel post filter: config registers, front, queues and back.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+---------------------------------------------
//  pixel in  | in  | push / full          | red_in green_in blue_in vignette_factor
//            |     |                      | row_end frame_end
//  result    | out | empty / pop          | red_out green_out blue_out row_last frame_last
//  config    | in  | cfg_write            | cfg_index cfg_data
//
//  One pixel per cycle is accepted while the command queue has room; a mid-row pixel
//  gives at most one result, a row end flushes one to three pixels, one result each.
//  Each result passes the back-end registers st_s1 and st_s2 before the result queue.
//  Reset clears pointers, counters and valid bits, not data; there is no clearing pass.
//  The back end stalls on result-queue credit, the front only on a full command queue.
module crt_pixel_postprocess #(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      red_in,
	input  logic [7:0]                      green_in,
	input  logic [7:0]                      blue_in,
	input  logic [7:0]                      vignette_factor,
	input  logic                            row_end,
	input  logic                            frame_end,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	output logic                            row_last,
	output logic                            frame_last,
	input  logic                            cfg_write,
	input  logic [crtpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                            cfg_data
);

	import crtpp_pkg::*;

	cfg_t    cfg_q;
	pixel_t  in_pixel;
	cmd_t    cmd_in;
	cmd_t    cmd_head;
	logic    in_fire;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_push;
	result_t res_in;
	result_t res_head;
	logic    res_full;
	logic    out_fire;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bleed: 1'b1, blur: 1'b1, vignette: 1'b1};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BLEED:    cfg_q.bleed    <= cfg_data;
				REG_BLUR:     cfg_q.blur     <= cfg_data;
				REG_VIGNETTE: cfg_q.vignette <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire  = push && !full;
	assign out_fire = pop && !empty;

	always_comb begin
		in_pixel.factor = vignette_factor;
		in_pixel.red    = red_in;
		in_pixel.green  = green_in;
		in_pixel.blue   = blue_in;
	end

	crtpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_fire),
		.pixel     (in_pixel),
		.row_end   (row_end),
		.frame_end (frame_end),
		.cmd       (cmd_in)
	);

	crtpp_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	crtpp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_head),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	crtpp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (out_fire),
		.rdata  (res_head),
		.empty  (empty),
		.count  (out_count)
	);

	assign red_out    = res_head.red;
	assign green_out  = res_head.green;
	assign blue_out   = res_head.blue;
	assign row_last   = res_head.row_last;
	assign frame_last = res_head.frame_last;

	a_res_room : assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full result queue");

	a_cmd_count : assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_count != '0)
		else $error("command taken from an empty command queue");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the CRT pixel post filter: directed rows, then random rows.
`timescale 1ns / 1ps

module tb_top;
	import crtpp_pkg::*;

	localparam int NUM_DIRECTED      = 24;
	localparam int NUM_SETTINGS      = 8;
	localparam int ITEMS_PER_SETTING = 51;
	localparam int SETTLE_CYCLES     = 12;
	localparam int HOLD_CYCLES       = 120;
	localparam int STUCK_LIMIT       = 2000;
	localparam int PRESSURE_SETTING  = 5;

	typedef struct packed {
		pixel_t  pix;
		logic    ends_row;
		logic    ends_frame;
		logic    known;
		result_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [7:0]           red_in;
	logic [7:0]           green_in;
	logic [7:0]           blue_in;
	logic [7:0]           vignette_factor;
	logic                 row_end;
	logic                 frame_end;
	logic                 empty;
	logic                 pop;
	logic [7:0]           red_out;
	logic [7:0]           green_out;
	logic [7:0]           blue_out;
	logic                 row_last;
	logic                 frame_last;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_data;

	crt_pixel_postprocess DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.vignette_factor (vignette_factor),
		.row_end         (row_end),
		.frame_end       (frame_end),
		.empty           (empty),
		.pop             (pop),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.row_last        (row_last),
		.frame_last      (frame_last),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// pixel = factor_red_green_blue; typed result = red, green, blue, row_last, frame_last
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		{32'hFF_FF_FF_FF, 1'b1, 1'b0, 1'b1, {8'd254, 8'd254, 8'd254, 1'b1, 1'b0}},
		{32'hFF_00_00_00, 1'b0, 1'b1, 1'b1, {8'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
		{32'h00_FF_FF_FF, 1'b1, 1'b0, 1'b1, {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
		{32'h80_80_40_20, 1'b1, 1'b1, 1'b1, {8'h40, 8'h20, 8'h10, 1'b1, 1'b1}},
		{32'hFF_FF_00_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hC8_00_FF_00, 1'b1, 1'b0, 1'b0, 26'd0},
		{32'hFF_FF_FF_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_FF_FF_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_FF_FF_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_00_00_00, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'h80_FF_00_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_01_02_03, 1'b1, 1'b0, 1'b0, 26'd0},
		{32'hFF_10_20_30, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_F0_E0_D0, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_55_AA_55, 1'b0, 1'b1, 1'b0, 26'd0},
		{32'h00_FF_FF_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_00_FF_00, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_FF_00_FF, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_AA_55_AA, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'h7F_FE_FE_FE, 1'b1, 1'b1, 1'b0, 26'd0},
		{32'h01_12_34_56, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFE_80_80_80, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_FE_FD_FC, 1'b0, 1'b0, 1'b0, 26'd0},
		{32'hFF_7F_80_81, 1'b1, 1'b0, 1'b0, 26'd0}
	};

	// filter state mirrored by the testbench
	logic    cfg_bleed;
	logic    cfg_blur;
	logic    cfg_vignette;
	pixel_t  row_window [4];
	int      row_fill;
	pixel_t  span [5];
	result_t awaited_pixels [$];

	int mismatch_count;
	int stuck_cycles;
	int results_seen;
	bit quiet;
	bit pressure_armed;
	bit pressure_done;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit at_edge(int k, int n, bit last_here);
		return (n - 4 + k == 0) || (last_here && k == 4);
	endfunction

	function automatic pixel_t bled(int k, int n, bit last_here);
		pixel_t c;
		int     r;
		int     b;
		c = span[k];
		if (!cfg_bleed || at_edge(k, n, last_here) || k < 1 || k > 3)
			return c;
		r = (3 * int'(span[k].red) + int'(span[k-1].red)) >> 2;
		b = (3 * int'(span[k].blue) + int'(span[k+1].blue)) >> 2;
		c.red  = r[7:0];
		c.blue = b[7:0];
		return c;
	endfunction

	function automatic logic [7:0] soften(int c, int l, int r);
		int v;
		v = c + (l + r) / 6;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [7:0] dim(int c, int f);
		int v;
		v = (c * f) >> 8;
		return v[7:0];
	endfunction

	function automatic result_t filtered(int k, int n, bit last_here, bit frame_done);
		pixel_t  p;
		pixel_t  l;
		pixel_t  r;
		result_t o;
		p = bled(k, n, last_here);
		if (cfg_blur && !at_edge(k, n, last_here) && k >= 1 && k <= 3) begin
			l = bled(k - 1, n, last_here);
			r = bled(k + 1, n, last_here);
			p.red   = soften(p.red, l.red, r.red);
			p.green = soften(p.green, l.green, r.green);
			p.blue  = soften(p.blue, l.blue, r.blue);
		end
		if (cfg_vignette) begin
			p.red   = dim(p.red, span[k].factor);
			p.green = dim(p.green, span[k].factor);
			p.blue  = dim(p.blue, span[k].factor);
		end
		o.red        = p.red;
		o.green      = p.green;
		o.blue       = p.blue;
		o.row_last   = last_here && k == 4;
		o.frame_last = last_here && k == 4 && frame_done;
		return o;
	endfunction

	// expected pixels caused by one accepted input pixel
	task automatic take_pixel(pixel_t px, bit ends_row, bit ends_frame);
		bit closes;
		int n;
		closes = ends_row || ends_frame;
		n = (row_fill > 4) ? 4 : row_fill;
		for (int i = 0; i < 4; i++)
			span[i] = row_window[i];
		span[4] = px;
		if (!closes) begin
			if (n >= 2)
				awaited_pixels.push_back(filtered(2, n, 1'b0, 1'b0));
			for (int i = 0; i < 3; i++)
				row_window[i] = row_window[i+1];
			row_window[3] = px;
			row_fill = (n < 4) ? n + 1 : 4;
		end else begin
			for (int k = 2; k <= 4; k++)
				if (n - 4 + k >= 0)
					awaited_pixels.push_back(filtered(k, n, 1'b1, ends_frame));
			for (int i = 0; i < 4; i++)
				row_window[i] = '0;
			row_fill = 0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		if (r < 30)
			return 8'd255;
		if (r < 40)
			return 8'($urandom_range(230, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	task automatic send_pixel(pixel_t px, bit ends_row, bit ends_frame);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push            <= 1'b1;
		red_in          <= px.red;
		green_in        <= px.green;
		blue_in         <= px.blue;
		vignette_factor <= px.factor;
		row_end         <= ends_row;
		frame_end       <= ends_frame;
		@(posedge clk);
		while (full) @(posedge clk);
		take_pixel(px, ends_row, ends_frame);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (awaited_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(logic bleed_on, logic blur_on, logic vignette_on);
		cfg_write <= 1'b1;
		cfg_index <= REG_BLEED;
		cfg_data  <= bleed_on;
		@(posedge clk);
		cfg_index <= REG_BLUR;
		cfg_data  <= blur_on;
		@(posedge clk);
		cfg_index <= REG_VIGNETTE;
		cfg_data  <= vignette_on;
		@(posedge clk);
		cfg_write    <= 1'b0;
		cfg_bleed    = bleed_on;
		cfg_blur     = blur_on;
		cfg_vignette = vignette_on;
	endtask

	task automatic send_random_rows(int budget);
		int     sent;
		int     len;
		int     r;
		bit     last;
		bit     ends_row;
		bit     ends_frame;
		pixel_t px;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 5);
			else if (r < 90)
				len = $urandom_range(6, 12);
			else
				len = $urandom_range(13, 24);
			for (int i = 0; i < len; i++) begin
				px.red    = pick_level();
				px.green  = pick_level();
				px.blue   = pick_level();
				px.factor = pick_level();
				last       = (i == len - 1);
				r          = $urandom_range(0, 9);
				ends_row   = last && r < 8;
				ends_frame = last && r >= 7;
				send_pixel(px, ends_row, ends_frame);
				sent++;
			end
		end
	endtask

	// result side
	initial begin
		result_t want;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (pressure_armed && !pressure_done) begin
				pressure_done = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				int stall;
				stall = pick_gap();
				if (stall > 0) begin
					pop <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			results_seen++;
			if (awaited_pixels.size() == 0) begin
				report_mismatch("transfer with nothing expected", red_out, 0);
			end else begin
				want = awaited_pixels.pop_front();
				if (red_out !== want.red)
					report_mismatch("red_out", red_out, want.red);
				if (green_out !== want.green)
					report_mismatch("green_out", green_out, want.green);
				if (blue_out !== want.blue)
					report_mismatch("blue_out", blue_out, want.blue);
				if (row_last !== want.row_last)
					report_mismatch("row_last", row_last, want.row_last);
				if (frame_last !== want.frame_last)
					report_mismatch("frame_last", frame_last, want.frame_last);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// pixel side and run control
	initial begin
		int unsigned setting;
		arst_n          <= 1'b0;
		push            <= 1'b0;
		red_in          <= '0;
		green_in        <= '0;
		blue_in         <= '0;
		vignette_factor <= '0;
		row_end         <= 1'b0;
		frame_end       <= 1'b0;
		cfg_write       <= 1'b0;
		cfg_index       <= REG_BLEED;
		cfg_data        <= 1'b0;
		cfg_bleed       = 1'b1;
		cfg_blur        = 1'b1;
		cfg_vignette    = 1'b1;
		row_fill        = 0;
		for (int i = 0; i < 4; i++)
			row_window[i] = '0;
		mismatch_count  = 0;
		stuck_cycles    = 0;
		results_seen    = 0;
		quiet           = 1'b0;
		pressure_armed  = 1'b0;
		pressure_done   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_pixel(directed_rows[i].pix, directed_rows[i].ends_row,
				directed_rows[i].ends_frame);
			if (directed_rows[i].known)
				awaited_pixels[$] = directed_rows[i].want;
		end
		settle();

		// every on/off combination of the three stages, all off first, all on last
		for (setting = 0; setting < NUM_SETTINGS; setting++) begin
			write_settings(setting[2], setting[1], setting[0]);
			quiet = (setting == 2 || setting == PRESSURE_SETTING);
			if (setting == PRESSURE_SETTING)
				pressure_armed = 1'b1;
			send_random_rows(ITEMS_PER_SETTING);
			settle();
		end

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
